// ===== design/linear_probing_hash_set_macros.svh =====
// assertion macros for the hash set checker
`ifndef LINEAR_PROBING_HASH_SET_MACROS_SVH
`define LINEAR_PROBING_HASH_SET_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LPHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lphs_pkg.sv =====
// shared types and codes for the linear probing hash set
package lphs_pkg;

    localparam int KEY_W    = 31;
    localparam int SLOT_W   = 10;
    localparam int PROBES_W = 11;
    localparam int STATUS_W = 3;

    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [PROBES_W-1:0] t_probes;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic  action;
        t_key  key;
        t_slot home;
    } t_entry;

endpackage

// ===== design/lphs_front.sv =====
// front end: takes words and works out the home slot by reciprocal multiplication
module lphs_front #(
    parameter int TABLE_SIZE = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hold,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_action,
    input  lphs_pkg::t_key    i_key,
    input  logic              i_full,
    output logic              o_push,
    output lphs_pkg::t_entry  o_word
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int KW = lphs_pkg::KEY_W;
    localparam int RW = KW + 1;
    localparam int PW = KW + RW;
    localparam int SH = KW + AW;
    localparam logic [63:0]   ONE   = 64'd1;
    localparam logic [63:0]   DIV   = 64'(TABLE_SIZE);
    localparam logic [RW-1:0] RECIP = RW'(((ONE << SH) + DIV - ONE) / DIV);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic           r_cnt, n_cnt;
    logic [PW-1:0]  r_prod, n_prod;
    logic [AW-1:0]  r_rem, n_rem;
    logic [KW-1:0]  quot;
    logic [KW-1:0]  quot_d;
    logic [AW-1:0]  red_rem;
    logic           r_act;
    lphs_pkg::t_key r_key;
    logic           accept;

    // quotient from the rounded-up reciprocal, exact for every key width value
    assign quot    = KW'(r_prod >> SH);
    assign quot_d  = quot * KW'(TABLE_SIZE);
    assign red_rem = AW'(r_key - quot_d);

    assign o_push  = r_busy && r_done && !i_full;
    assign o_ready = !i_hold && (!r_busy || o_push);
    assign accept  = i_valid && o_ready;

    assign o_word.action = r_act;
    assign o_word.key    = r_key;
    assign o_word.home   = lphs_pkg::t_slot'(r_rem);

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_prod = r_prod;
        n_rem  = r_rem;
        if (accept) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = 1'b0;
        end else if (o_push) begin
            n_busy = 1'b0;
        end else if (r_busy && !r_done) begin
            if (!r_cnt) begin
                n_prod = PW'(r_key) * PW'(RECIP);
                n_cnt  = 1'b1;
            end else begin
                n_rem  = red_rem;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_rem  <= n_rem;
        if (accept) begin
            r_act <= i_action;
            r_key <= i_key;
        end
    end

endmodule

// ===== design/lphs_queue.sv =====
// two-entry queue between front and back
module lphs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lphs_pkg::t_entry i_word,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output lphs_pkg::t_entry o_word
);

    lphs_pkg::t_entry r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule

// ===== design/lphs_back.sv =====
// back end: slot memory, probe sequencer and result register
module lphs_back #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    output logic                o_clearing,
    input  logic                i_q_valid,
    input  lphs_pkg::t_entry    i_q_word,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output lphs_pkg::t_status   o_status,
    output lphs_pkg::t_slot     o_slot,
    output lphs_pkg::t_probes   o_probes
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int NW = $clog2(TABLE_SIZE + 1);
    localparam int MW = lphs_pkg::KEY_W + 1;
    localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_PROBE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_next, n_next;
    logic [NW-1:0]     r_n, n_n;
    logic              r_act;
    lphs_pkg::t_key    r_key;
    logic [MW-1:0]     r_mem [TABLE_SIZE];
    logic [MW-1:0]     r_rd;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [MW-1:0]     wr_data;
    logic              r_o_valid, n_o_valid;
    lphs_pkg::t_status r_status, n_status;
    lphs_pkg::t_slot   r_slot, n_slot;
    lphs_pkg::t_probes r_probes, n_probes;
    logic [AW-1:0]     home;
    logic              start;
    logic              slot_empty, slot_match, lap_done, fin;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == LAST) ? '0 : p + 1'b1;
    endfunction

    assign home       = i_q_word.home[AW-1:0];
    assign start      = (r_state == S_IDLE) && i_q_valid && (!r_o_valid || i_ready);
    assign o_q_pop    = start;
    assign o_clearing = (r_state == S_CLEAR);

    assign slot_empty = !r_rd[MW-1];
    assign slot_match = r_rd[MW-1] && (r_rd[MW-2:0] == r_key);
    assign lap_done   = (r_n == NW'(TABLE_SIZE));
    assign fin        = slot_empty || slot_match || lap_done;

    assign o_valid  = r_o_valid;
    assign o_status = r_status;
    assign o_slot   = r_slot;
    assign o_probes = r_probes;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_next    = r_next;
        n_n       = r_n;
        n_o_valid = r_o_valid;
        n_status  = r_status;
        n_slot    = r_slot;
        n_probes  = r_probes;
        rd_addr   = r_next;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = {1'b0, {lphs_pkg::KEY_W{1'b1}}};
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_pos == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            S_IDLE: begin
                rd_addr = home;
                if (start) begin
                    n_pos   = home;
                    n_next  = f_inc(home);
                    n_n     = NW'(1);
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (fin) begin
                    n_state   = S_IDLE;
                    n_o_valid = 1'b1;
                    n_probes  = lphs_pkg::t_probes'(r_n);
                    n_slot    = '0;
                    if (slot_empty) begin
                        if (r_act == lphs_pkg::ACT_SEARCH) begin
                            n_status = lphs_pkg::ST_NOT_FOUND;
                        end else begin
                            n_status = lphs_pkg::ST_INSERTED;
                            n_slot   = lphs_pkg::t_slot'(r_pos);
                            wr_en    = 1'b1;
                            wr_data  = {1'b1, r_key};
                        end
                    end else if (slot_match) begin
                        if (r_act == lphs_pkg::ACT_SEARCH) begin
                            n_status = lphs_pkg::ST_FOUND;
                            n_slot   = lphs_pkg::t_slot'(r_pos);
                        end else begin
                            n_status = lphs_pkg::ST_PRESENT;
                        end
                    end else if (r_act == lphs_pkg::ACT_SEARCH) begin
                        n_status = lphs_pkg::ST_NOT_FOUND;
                    end else begin
                        n_status = lphs_pkg::ST_FULL;
                    end
                end else begin
                    n_pos  = r_next;
                    n_next = f_inc(r_next);
                    n_n    = r_n + 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_pos     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next   <= n_next;
        r_n      <= n_n;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_probes <= n_probes;
        if (start) begin
            r_act <= i_q_word.action;
            r_key <= i_q_word.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

endmodule

// ===== design/linear_probing_hash_set.sv =====
// top level of the linear probing hash set
//
//   channel  | handshake                  | word
//   ---------+----------------------------+------------------------------
//   input    | i_in_valid / o_in_ready    | i_action, i_key
//   output   | o_out_valid / i_out_ready  | o_status, o_slot, o_probes
//
// front end: a reciprocal multiply then a reduce to the home slot, one word at a time
// back end: a word is taken in the idle state, then one slot read a cycle, one per probe
// a word passes the multiply, the reduce, the queue and the idle state, then its probes
// the front works on the next word while the back probes; a two-entry queue sits between
// after reset a clearing pass empties every slot of the memory; no word taken
// a new probe starts only once the result register is free or being taken
module linear_probing_hash_set #(
    parameter int TABLE_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [30:0] i_key,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_slot,
    output logic [10:0] o_probes
);

    lphs_pkg::t_entry  front_word, q_word;
    lphs_pkg::t_status status;
    logic              push, q_full, q_valid, q_pop, clearing;

    lphs_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (clearing),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_action(i_action),
        .i_key   (i_key),
        .i_full  (q_full),
        .o_push  (push),
        .o_word  (front_word)
    );

    lphs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_word (front_word),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_word (q_word)
    );

    lphs_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_clearing(clearing),
        .i_q_valid (q_valid),
        .i_q_word  (q_word),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_status  (status),
        .o_slot    (o_slot),
        .o_probes  (o_probes)
    );

    assign o_status = status;

endmodule

// ===== design/lphs_checker.sv =====
// port-level checks for the hash set, bound to the top level
`include "linear_probing_hash_set_macros.svh"

module lphs_checker #(
    parameter int TABLE_SIZE = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [9:0]  o_slot,
    input logic [10:0] o_probes
);

    `LPHS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_slot) && $stable(o_probes), "result word changed while stalled")
    `LPHS_ASSERT_NOW(a_status_code, o_out_valid, o_status <= 3'(lphs_pkg::ST_NOT_FOUND), "status code out of range")
    `LPHS_ASSERT_NOW(a_probe_range, o_out_valid, o_probes >= 11'd1 && o_probes <= 11'(TABLE_SIZE), "probe count out of range")
    `LPHS_ASSERT_NOW(a_slot_zero, o_out_valid && (o_status == 3'(lphs_pkg::ST_PRESENT) || o_status == 3'(lphs_pkg::ST_FULL) || o_status == 3'(lphs_pkg::ST_NOT_FOUND)), o_slot == 10'd0, "slot not zero for a miss")
    `LPHS_ASSERT_NOW(a_full_lap, o_out_valid && o_status == 3'(lphs_pkg::ST_FULL), o_probes == 11'(TABLE_SIZE), "full table without a whole lap")

endmodule

bind linear_probing_hash_set lphs_checker #(.TABLE_SIZE(TABLE_SIZE)) u_lphs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_status   (o_status),
    .o_slot     (o_slot),
    .o_probes   (o_probes)
);

// ===== tb/sv/hash_set_checker.sv =====
// checker for the linear probing hash set: predicts each answer and compares it field by field
`timescale 1ns / 1ps

module hash_set_checker
    import lphs_pkg::*;
#(
    parameter int TABLE_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_action,
    input  logic [30:0] i_key,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [9:0]  i_slot,
    input  logic [10:0] i_probes,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        t_status status;
        t_slot   slot;
        t_probes probes;
    } t_answer;

    t_key    table_keys [TABLE_SIZE];
    bit      table_used [TABLE_SIZE];
    t_answer answers_due [$];
    int      mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    function automatic t_answer probe_table(input logic act, input t_key k);
        t_answer ans;
        int unsigned pos;
        int unsigned n;
        bit done;
        ans.status = (act == ACT_SEARCH) ? ST_NOT_FOUND : ST_FULL;
        ans.slot = '0;
        ans.probes = t_probes'(TABLE_SIZE);
        pos = k % TABLE_SIZE;
        done = 1'b0;
        for (n = 1; n <= TABLE_SIZE; n++) begin
            if (!done) begin
                if (!table_used[pos]) begin
                    if (act == ACT_INSERT) begin
                        table_keys[pos] = k;
                        table_used[pos] = 1'b1;
                        ans.status = ST_INSERTED;
                        ans.slot = t_slot'(pos);
                    end else begin
                        ans.status = ST_NOT_FOUND;
                    end
                    ans.probes = t_probes'(n);
                    done = 1'b1;
                end else if (table_keys[pos] == k) begin
                    if (act == ACT_SEARCH) begin
                        ans.status = ST_FOUND;
                        ans.slot = t_slot'(pos);
                    end else begin
                        ans.status = ST_PRESENT;
                    end
                    ans.probes = t_probes'(n);
                    done = 1'b1;
                end else begin
                    pos = (pos + 1) % TABLE_SIZE;
                end
            end
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int s = 0; s < TABLE_SIZE; s++) begin
                table_keys[s] = '1;
                table_used[s] = 1'b0;
            end
            answers_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                answers_due.push_back(probe_table(i_action, i_key));
            end
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("word with nothing due, status", i_status, 0);
                end else begin
                    want = answers_due.pop_front();
                    if (i_status !== want.status) begin
                        report_mismatch("status", i_status, want.status);
                    end
                    if (i_slot !== want.slot) begin
                        report_mismatch("slot", i_slot, want.slot);
                    end
                    if (i_probes !== want.probes) begin
                        report_mismatch("probes", i_probes, want.probes);
                    end
                end
            end
        end
        o_pending <= answers_due.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the hash set testbench: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module testbench;
    import lphs_pkg::*;

    localparam int TABLE_SIZE = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = ACT_INSERT;
    logic [30:0] key = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [10:0] probes;
    int          fail_count;
    int          pending;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    t_key        stored_keys [$];

    linear_probing_hash_set #(
        .TABLE_SIZE(TABLE_SIZE)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_action   (action),
        .i_key      (key),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_status   (status),
        .o_slot     (slot),
        .o_probes   (probes)
    );

    hash_set_checker #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_action    (action),
        .i_key       (key),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_status    (status),
        .i_slot      (slot),
        .i_probes    (probes),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input logic act, input t_key k);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        key <= k;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_answers();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random(input int count);
        int unsigned pick;
        t_key k;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            k = t_key'($urandom);
            if (pick < 45) begin
                send_word(ACT_SEARCH, stored_keys[$urandom_range(stored_keys.size() - 1)]);
            end else if (pick < 65) begin
                send_word(ACT_SEARCH, k);
            end else if (pick < 85) begin
                send_word(ACT_INSERT, stored_keys[$urandom_range(stored_keys.size() - 1)]);
            end else begin
                send_word(ACT_INSERT, k);
            end
        end
    endtask

    initial begin
        send_idle_pct = 19;
        recv_idle_pct = 72;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, extremes of the key, duplicate, collisions and wrap-around
        send_word(ACT_SEARCH, t_key'(5));
        send_word(ACT_INSERT, '0);
        send_word(ACT_INSERT, '1);
        send_word(ACT_INSERT, '1);
        send_word(ACT_INSERT, t_key'(31));
        send_word(ACT_SEARCH, t_key'(31));
        send_word(ACT_SEARCH, t_key'(47));
        send_word(ACT_INSERT, t_key'(16));
        send_word(ACT_INSERT, '0);
        send_word(ACT_SEARCH, t_key'(32'h7FFF_FFF0));
        stored_keys = '{t_key'(0), '1, t_key'(31), t_key'(16)};
        // one long cluster fills the rest of the table
        for (int n = 0; n < 12; n++) begin
            send_word(ACT_INSERT, t_key'(3 + 16 * n));
            stored_keys.push_back(t_key'(3 + 16 * n));
        end
        send_word(ACT_INSERT, t_key'(50));
        send_word(ACT_SEARCH, t_key'(1000003));
        send_word(ACT_SEARCH, t_key'(179));
        send_word(ACT_SEARCH, '1);
        drain_answers();

        send_random(150);
        send_idle_pct = 72;
        recv_idle_pct = 19;
        send_random(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(150);

        drain_answers();
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/lphs_pkg.sv
design/lphs_front.sv
design/lphs_queue.sv
design/lphs_back.sv
design/linear_probing_hash_set.sv
design/lphs_checker.sv
tb/sv/hash_set_checker.sv
tb/sv/testbench.sv
